/* hw/rtl/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CP_W        = 21;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

	// Prefix codes of lead and continuation bytes
	localparam logic [0:0] PFX_ASCII = 1'b0;
	localparam logic [2:0] PFX_LEAD2 = 3'b110;
	localparam logic [3:0] PFX_LEAD3 = 4'b1110;
	localparam logic [4:0] PFX_LEAD4 = 5'b11110;
	localparam logic [1:0] PFX_CONT  = 2'b10;

	// Bytes still expected in an open sequence
	localparam logic [1:0] REM_NONE = 2'd0;
	localparam logic [1:0] REM_ONE  = 2'd1;
	localparam logic [1:0] REM_TWO  = 2'd2;
	localparam logic [1:0] REM_THREE = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            malformed;
		logic            final_char;
	} result_t;

endpackage

/* hw/rtl/utf8d_in_stage.sv */
// Input register stage of the UTF-8 stream decoder.
module utf8d_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [utf8d_pkg::BYTE_W-1:0]  in_byte,
	input  logic                          in_last,
	input  logic                          take,      // core consumes the held item
	output logic                          in_ready,
	output utf8d_pkg::in_item_t           item_s1
);

	logic                         valid_s1;
	logic [utf8d_pkg::BYTE_W-1:0] byte_s1;
	logic                         eot_s1;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eot_s1  <= in_last;
		end
	end

	assign item_s1 = '{valid: valid_s1, text_byte: byte_s1, end_of_text: eot_s1};

endmodule

/* hw/rtl/utf8d_core.sv */
// Sequence state, decode logic and result register of the UTF-8 stream decoder.
module utf8d_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8d_pkg::in_item_t  item_s1,
	output logic                 take,
	output logic                 res_valid,
	input  logic                 res_ready,
	output utf8d_pkg::result_t   res
);

	logic [1:0]                 rem_q;
	logic [utf8d_pkg::CP_W-1:0] acc_q;
	logic                       bad_q;

	logic                       res_valid_q;
	utf8d_pkg::result_t         res_q;

	logic [1:0]                 rem_d;
	logic [utf8d_pkg::CP_W-1:0] acc_d;
	logic                       bad_d;
	logic                       emit;
	utf8d_pkg::result_t         res_d;

	logic [utf8d_pkg::BYTE_W-1:0] b;
	logic                         eot;
	logic                         cont_bad;
	logic [utf8d_pkg::CP_W-1:0]   acc_shift;
	logic [1:0]                   rem_dec;

	// Result slot is free when empty or being drained this cycle
	assign take = !res_valid_q || res_ready;

	assign b         = item_s1.text_byte;
	assign eot       = item_s1.end_of_text;
	assign cont_bad  = (b[7:6] != utf8d_pkg::PFX_CONT);
	assign acc_shift = {acc_q[utf8d_pkg::CP_W-7:0], b[5:0]};
	assign rem_dec   = rem_q - 2'd1;

	always_comb begin
		rem_d = rem_q;
		acc_d = acc_q;
		bad_d = bad_q;
		emit  = 1'b0;
		res_d = '{code_point: utf8d_pkg::REPLACEMENT_CHAR, malformed: 1'b1, final_char: eot};
		if (rem_q == utf8d_pkg::REM_NONE) begin
			if (b[7] == utf8d_pkg::PFX_ASCII) begin
				emit             = 1'b1;
				res_d.code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, b};
				res_d.malformed  = 1'b0;
			end else if (b[7:5] == utf8d_pkg::PFX_LEAD2 || b[7:4] == utf8d_pkg::PFX_LEAD3 ||
					b[7:3] == utf8d_pkg::PFX_LEAD4) begin
				bad_d = 1'b0;
				if (b[7:5] == utf8d_pkg::PFX_LEAD2) begin
					rem_d = utf8d_pkg::REM_ONE;
					acc_d = {16'd0, b[4:0]};
				end else if (b[7:4] == utf8d_pkg::PFX_LEAD3) begin
					rem_d = utf8d_pkg::REM_TWO;
					acc_d = {17'd0, b[3:0]};
				end else begin
					rem_d = utf8d_pkg::REM_THREE;
					acc_d = {18'd0, b[2:0]};
				end
				// lead byte cut off by end of text
				if (eot) begin
					emit  = 1'b1;
					rem_d = utf8d_pkg::REM_NONE;
					acc_d = '0;
					bad_d = 1'b0;
				end
			end else begin
				emit = 1'b1;   // stray continuation or invalid lead
			end
		end else begin
			bad_d = bad_q | cont_bad;
			acc_d = acc_shift;
			rem_d = rem_dec;
			if (rem_dec == utf8d_pkg::REM_NONE) begin
				emit             = 1'b1;
				res_d.malformed  = bad_d;
				res_d.code_point = bad_d ? utf8d_pkg::REPLACEMENT_CHAR : acc_shift;
				acc_d            = '0;
				bad_d            = 1'b0;
			end else if (eot) begin
				emit  = 1'b1;
				rem_d = utf8d_pkg::REM_NONE;
				acc_d = '0;
				bad_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= utf8d_pkg::REM_NONE;
			acc_q       <= '0;
			bad_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= item_s1.valid && emit;
			if (item_s1.valid) begin
				rem_q <= rem_d;
				acc_q <= acc_d;
				bad_q <= bad_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.valid && emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* hw/rtl/utf8_stream_decoder_top.sv */
// Top level of the UTF-8 stream decoder.
// Decodes a UTF-8 byte stream, one byte per item on the slave side, into code
// points on the master side. An input byte is registered, then decoded against
// the open-sequence state and written to a result register, so the block takes
// one byte every cycle while m_tready does not stall a full result register. A
// result item is offered on the master side as soon as its completing byte has
// moved from the input register into the result register.
// Only the last byte of a sequence (or a byte that cannot start a sequence, or
// the byte flagged tlast) yields a result item; other bytes yield none.
// Malformed input (stray continuation, invalid lead, a non-10xxxxxx byte inside
// a sequence, or a sequence cut off by tlast) gives U+FFFD with tuser set.
// Overlong forms and surrogates pass unchecked. After a tlast byte the decoder
// is idle and the next byte opens a new text. s_tready follows m_tready in the
// same cycle whenever both registers are full.
module utf8_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] text_byte
	input  logic        s_tlast,    // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [20:0] code_point, [23:21] zero
	output logic        m_tuser,    // [0] malformed
	output logic        m_tlast     // final_char
);

	utf8d_pkg::in_item_t item_s1;
	utf8d_pkg::result_t  res;
	logic                take;

	utf8d_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.take     (take),
		.in_ready (s_tready),
		.item_s1  (item_s1)
	);

	utf8d_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.take      (take),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pad the code point to whole bytes
	assign m_tdata = {{(utf8d_pkg::OUT_TDATA_W-utf8d_pkg::CP_W){1'b0}}, res.code_point};
	assign m_tuser = res.malformed;
	assign m_tlast = res.final_char;

endmodule

/* hw/rtl/utf8d_checker.sv */
// Port-level checker for the UTF-8 stream decoder, with its bind.
module utf8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("result changed while stalled");

	// a new result follows a byte accepted through the input and result registers
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a causing byte");

	// malformed results carry the replacement character
	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[20:0] == 21'h00FFFD)
		else $error("malformed result is not U+FFFD");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:21] == 3'd0)
		else $error("tdata padding not zero");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
